>>> hdl/sschit_pkg.sv
// Shared types and constants for the swept sphere versus cylinder hit test.
package sschit_pkg;

    localparam logic [30:0] SPHERE_RADIUS_RESET = 31'd7864;
    // Segments whose squared x-z length is below about 1e-6 (Q32.32) get t = 0.
    localparam logic [66:0] LEN_EPS = 67'd4295;
    localparam int unsigned T_BITS = 16;
    // Edges from an accepted start to the edge that takes its result.
    localparam int unsigned LATENCY = 23;

    typedef struct packed {
        logic signed [31:0] seg_start_x;
        logic signed [31:0] seg_start_y;
        logic signed [31:0] seg_start_z;
        logic signed [31:0] seg_end_x;
        logic signed [31:0] seg_end_y;
        logic signed [31:0] seg_end_z;
        logic signed [31:0] cyl_base_x;
        logic signed [31:0] cyl_base_y;
        logic signed [31:0] cyl_base_z;
        logic [30:0]        cyl_height;
        logic [30:0]        cyl_radius;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
    } result_t;

    // Values carried along the pipeline.
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [30:0]        h;
        logic [30:0]        cr;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
    } carry_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        logic [32:0] r;
        r = v[32] ? 33'(-v) : 33'(v);
        return r;
    endfunction

    function automatic logic signed [32:0] sdiff(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] r;
        r = $signed({a[31], a}) - $signed({b[31], b});
        return r;
    endfunction

endpackage

>>> hdl/swept_sphere_cylinder_hit_top.sv
// Pipelined swept sphere versus upright cylinder hit test.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------
//  input     | start, busy          | item   (sschit_pkg::item_t)
//  result    | done (one cycle)     | result (sschit_pkg::result_t)
//  config    | cfg_we               | cfg_wdata (sphere radius)
//
// One item per cycle. t comes from a 16-stage restoring divider, one quotient
// bit per stage, with the product, lerp and distance stages around it.
// busy is always low. Reset clears the valid bits and restores the radius.
module swept_sphere_cylinder_hit_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sschit_pkg::item_t    item,
    output logic                 done,
    output sschit_pkg::result_t  result,
    input  logic                 cfg_we,
    input  logic [30:0]          cfg_wdata
);
    import sschit_pkg::*;

    localparam int DIV_N = T_BITS;

    logic [30:0] rs_reg;

    // stage 1: differences
    logic               v1_reg;
    carry_t             c1_reg;
    logic signed [32:0] vx1_reg, vz1_reg;

    // stage 2: products
    logic               v2_reg;
    carry_t             c2_reg;
    logic [65:0]        lxx2_reg, lzz2_reg, tx2_reg, tz2_reg;
    logic               nx2_reg, nz2_reg;

    // divider stages
    logic               dv_reg   [0:DIV_N];
    carry_t             dc_reg   [0:DIV_N];
    logic [67:0]        drem_reg [0:DIV_N];
    logic [66:0]        dlen_reg [0:DIV_N];
    logic [15:0]        dq_reg   [0:DIV_N];
    logic               done_reg [0:DIV_N];
    logic               dzero_reg[0:DIV_N];

    // stage 4: t times delta
    logic               v4_reg;
    carry_t             c4_reg;
    logic signed [50:0] px4_reg, py4_reg, pz4_reg;

    // stage 5: closest point
    logic               v5_reg;
    carry_t             c5_reg;
    logic signed [31:0] px5_reg, py5_reg, pz5_reg;

    // stage 6: height test and squares
    logic               v6_reg;
    logic               h6_reg;
    logic [65:0]        ox6_reg, oz6_reg;
    logic [63:0]        lim6_reg;
    logic signed [31:0] px6_reg, py6_reg, pz6_reg;

    logic               done_out_reg;
    result_t            result_reg;

    // stage 3 combinational
    logic [66:0] len_next, pos_next, neg_next, dot_next;
    logic        gen_next;

    // stage 4 / 5 / 6 / 7 combinational
    logic [16:0]        t_next;
    logic signed [34:0] lo_next, hi_next, pyw_next;
    logic signed [32:0] ox_next, oz_next;
    logic [31:0]        tr_next;
    logic [66:0]        dist_next;

    assign busy = 1'b0;

    always_comb
    begin
        len_next = {1'b0, lxx2_reg} + {1'b0, lzz2_reg};
        pos_next = (nx2_reg ? 67'd0 : {1'b0, tx2_reg}) + (nz2_reg ? 67'd0 : {1'b0, tz2_reg});
        neg_next = (nx2_reg ? {1'b0, tx2_reg} : 67'd0) + (nz2_reg ? {1'b0, tz2_reg} : 67'd0);
        dot_next = pos_next - neg_next;
        gen_next = (len_next >= LEN_EPS) && (pos_next > neg_next);
    end

    always_comb
    begin
        if (done_reg[DIV_N])
        begin
            t_next = 17'h10000;
        end
        else if (dzero_reg[DIV_N])
        begin
            t_next = 17'd0;
        end
        else
        begin
            t_next = {1'b0, dq_reg[DIV_N]};
        end
        pyw_next = $signed({{3{py5_reg[31]}}, py5_reg});
        lo_next  = $signed({{3{c5_reg.cy[31]}}, c5_reg.cy}) - $signed({4'd0, rs_reg});
        hi_next  = $signed({{3{c5_reg.cy[31]}}, c5_reg.cy}) + $signed({4'd0, c5_reg.h})
                   + $signed({4'd0, rs_reg});
        ox_next  = sdiff(px5_reg, c5_reg.cx);
        oz_next  = sdiff(pz5_reg, c5_reg.cz);
        tr_next  = {1'b0, c5_reg.cr} + {1'b0, rs_reg};
        dist_next = {1'b0, ox6_reg} + {1'b0, oz6_reg};
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg       <= SPHERE_RADIUS_RESET;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            done_out_reg <= 1'b0;
            for (int i = 0; i <= DIV_N; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                rs_reg <= cfg_wdata;
            end
            v1_reg    <= start && !busy;
            v2_reg    <= v1_reg;
            dv_reg[0] <= v2_reg;
            for (int i = 1; i <= DIV_N; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
            v4_reg       <= dv_reg[DIV_N];
            v5_reg       <= v4_reg;
            v6_reg       <= v5_reg;
            done_out_reg <= v6_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        c1_reg.sx <= item.seg_start_x;
        c1_reg.sy <= item.seg_start_y;
        c1_reg.sz <= item.seg_start_z;
        c1_reg.cx <= item.cyl_base_x;
        c1_reg.cy <= item.cyl_base_y;
        c1_reg.cz <= item.cyl_base_z;
        c1_reg.h  <= item.cyl_height;
        c1_reg.cr <= item.cyl_radius;
        c1_reg.dx <= sdiff(item.seg_end_x, item.seg_start_x);
        c1_reg.dy <= sdiff(item.seg_end_y, item.seg_start_y);
        c1_reg.dz <= sdiff(item.seg_end_z, item.seg_start_z);
        vx1_reg   <= sdiff(item.cyl_base_x, item.seg_start_x);
        vz1_reg   <= sdiff(item.cyl_base_z, item.seg_start_z);

        c2_reg   <= c1_reg;
        lxx2_reg <= mag33(c1_reg.dx) * mag33(c1_reg.dx);
        lzz2_reg <= mag33(c1_reg.dz) * mag33(c1_reg.dz);
        tx2_reg  <= mag33(vx1_reg) * mag33(c1_reg.dx);
        tz2_reg  <= mag33(vz1_reg) * mag33(c1_reg.dz);
        nx2_reg  <= vx1_reg[32] != c1_reg.dx[32];
        nz2_reg  <= vz1_reg[32] != c1_reg.dz[32];

        dc_reg[0]    <= c2_reg;
        drem_reg[0]  <= {1'b0, dot_next};
        dlen_reg[0]  <= len_next;
        dq_reg[0]    <= 16'd0;
        done_reg[0]  <= gen_next && (dot_next >= len_next);
        dzero_reg[0] <= !gen_next;

        // one restoring quotient bit per stage
        for (int i = 1; i <= DIV_N; i++)
        begin
            logic [67:0] sh;
            logic        ge;
            sh = {drem_reg[i-1][66:0], 1'b0};
            ge = sh >= {1'b0, dlen_reg[i-1]};
            drem_reg[i]  <= ge ? (sh - {1'b0, dlen_reg[i-1]}) : sh;
            dq_reg[i]    <= {dq_reg[i-1][14:0], ge};
            dlen_reg[i]  <= dlen_reg[i-1];
            dc_reg[i]    <= dc_reg[i-1];
            done_reg[i]  <= done_reg[i-1];
            dzero_reg[i] <= dzero_reg[i-1];
        end

        c4_reg  <= dc_reg[DIV_N];
        px4_reg <= dc_reg[DIV_N].dx * $signed({1'b0, t_next});
        py4_reg <= dc_reg[DIV_N].dy * $signed({1'b0, t_next});
        pz4_reg <= dc_reg[DIV_N].dz * $signed({1'b0, t_next});

        // arithmetic shift floors the product as the lerp needs
        c5_reg  <= c4_reg;
        px5_reg <= 32'(c4_reg.sx + 32'(px4_reg >>> T_BITS));
        py5_reg <= 32'(c4_reg.sy + 32'(py4_reg >>> T_BITS));
        pz5_reg <= 32'(c4_reg.sz + 32'(pz4_reg >>> T_BITS));

        h6_reg   <= (pyw_next >= lo_next) && (pyw_next <= hi_next);
        ox6_reg  <= mag33(ox_next) * mag33(ox_next);
        oz6_reg  <= mag33(oz_next) * mag33(oz_next);
        lim6_reg <= tr_next * tr_next;
        px6_reg  <= px5_reg;
        py6_reg  <= py5_reg;
        pz6_reg  <= pz5_reg;

        if (h6_reg && (dist_next <= {3'd0, lim6_reg}))
        begin
            result_reg.hit   <= 1'b1;
            result_reg.hit_x <= px6_reg;
            result_reg.hit_y <= py6_reg;
            result_reg.hit_z <= pz6_reg;
        end
        else
        begin
            result_reg <= '0;
        end
    end

    assign done   = done_out_reg;
    assign result = result_reg;

endmodule

>>> hdl/sschit_checker.sv
// Port-level checks for the hit test pipeline, bound to the top level.
module sschit_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input sschit_pkg::result_t result
);
    import sschit_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("transfer without result");

    a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result without transfer");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.hit) |-> (result.hit_x == 0 && result.hit_y == 0 &&
                                   result.hit_z == 0))
        else $error("miss carries a point");

endmodule

bind swept_sphere_cylinder_hit_top sschit_checker u_sschit_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

>>> tb/sv/tb_swept_sphere_cylinder_hit_top.sv
// Self-checking testbench for the swept sphere versus cylinder hit test.
module tb_swept_sphere_cylinder_hit_top;
    import sschit_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned ONE = 65536;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        done;
    result_t     result;
    logic        cfg_we;
    logic [30:0] cfg_wdata;

    logic [30:0] radius_shadow;
    result_t     pending_hits[$];
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned hits_seen;
    int unsigned stall_cycles;
    logic        accepted_now;

    swept_sphere_cylinder_hit_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Closest point on the segment and the two range tests, at full width.
    function automatic result_t predict_hit(input item_t it, input logic [30:0] rs_in);
        logic signed [127:0] sx, sy, sz, ex, ey, ez, cx, cy, cz, h, cr, rs;
        logic signed [127:0] dx, dy, dz, len_sq, dot, tt, px, py, pz, ox, oz;
        logic signed [127:0] dist_sq, lim;
        result_t r;
        sx = it.seg_start_x;
        sy = it.seg_start_y;
        sz = it.seg_start_z;
        ex = it.seg_end_x;
        ey = it.seg_end_y;
        ez = it.seg_end_z;
        cx = it.cyl_base_x;
        cy = it.cyl_base_y;
        cz = it.cyl_base_z;
        h  = {97'd0, it.cyl_height};
        cr = {97'd0, it.cyl_radius};
        rs = {97'd0, rs_in};
        dx = ex - sx;
        dy = ey - sy;
        dz = ez - sz;
        len_sq = dx * dx + dz * dz;
        tt = 0;
        if (len_sq >= 4295) begin
            dot = (cx - sx) * dx + (cz - sz) * dz;
            if (dot <= 0)
                tt = 0;
            else if (dot >= len_sq)
                tt = ONE;
            else
                tt = (dot <<< 16) / len_sq;
        end
        px = sx + ((dx * tt) >>> 16);
        py = sy + ((dy * tt) >>> 16);
        pz = sz + ((dz * tt) >>> 16);
        r = '0;
        if (py >= cy - rs && py <= cy + h + rs) begin
            ox = px - cx;
            oz = pz - cz;
            dist_sq = ox * ox + oz * oz;
            lim = (cr + rs) * (cr + rs);
            if (dist_sq <= lim)
            begin
                r.hit = 1'b1;
                r.hit_x = px[31:0];
                r.hit_y = py[31:0];
                r.hit_z = pz[31:0];
            end
        end
        return r;
    endfunction

    // Hold start high; the transfer happens at the first edge with busy low.
    task automatic send_item(input item_t it);
        item <= it;
        start <= 1'b1;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        pending_hits.push_back(predict_hit(it, radius_shadow));
        items_sent++;
    endtask

    task automatic pause_sender(input int unsigned n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_radius(input logic [30:0] v);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        radius_shadow = v;
    endtask

    function automatic logic signed [31:0] units(input int v);
        return 32'(v * int'(ONE));
    endfunction

    function automatic item_t full_random_item();
        item_t it;
        it.seg_start_x = $urandom;
        it.seg_start_y = $urandom;
        it.seg_start_z = $urandom;
        it.seg_end_x = $urandom;
        it.seg_end_y = $urandom;
        it.seg_end_z = $urandom;
        it.cyl_base_x = $urandom;
        it.cyl_base_y = $urandom;
        it.cyl_base_z = $urandom;
        it.cyl_height = 31'($urandom);
        it.cyl_radius = 31'($urandom);
        return it;
    endfunction

    function automatic logic signed [31:0] jitter(input logic signed [31:0] c, input int span);
        return c + 32'($urandom_range(0, 2 * span * ONE)) - units(span);
    endfunction

    // Segment passing close to a small cylinder, so both outcomes show up.
    function automatic item_t near_item();
        item_t it;
        it.cyl_base_x = jitter(0, 40);
        it.cyl_base_y = jitter(0, 40);
        it.cyl_base_z = jitter(0, 40);
        it.cyl_height = 31'($urandom_range(0, 6 * ONE));
        it.cyl_radius = 31'($urandom_range(0, 3 * ONE));
        it.seg_start_x = jitter(it.cyl_base_x, 6);
        it.seg_start_y = jitter(it.cyl_base_y + 3 * ONE, 5);
        it.seg_start_z = jitter(it.cyl_base_z, 6);
        if ($urandom_range(0, 9) == 0)
        begin
            // nearly a point
            it.seg_end_x = it.seg_start_x + 32'($urandom_range(0, 140)) - 70;
            it.seg_end_y = jitter(it.seg_start_y, 1);
            it.seg_end_z = it.seg_start_z + 32'($urandom_range(0, 140)) - 70;
        end
        else
        begin
            it.seg_end_x = jitter(it.cyl_base_x, 6);
            it.seg_end_y = jitter(it.cyl_base_y + 3 * ONE, 5);
            it.seg_end_z = jitter(it.cyl_base_z, 6);
        end
        return it;
    endfunction

    function automatic item_t line_item(input int ax, input int az, input int bx, input int bz,
                                        input logic signed [31:0] cx,
                                        input logic signed [31:0] cz,
                                        input logic signed [31:0] cy,
                                        input logic [30:0] h, input logic [30:0] r);
        item_t it;
        it.seg_start_x = units(ax);
        it.seg_start_y = 0;
        it.seg_start_z = units(az);
        it.seg_end_x = units(bx);
        it.seg_end_y = 0;
        it.seg_end_z = units(bz);
        it.cyl_base_x = cx;
        it.cyl_base_y = cy;
        it.cyl_base_z = cz;
        it.cyl_height = h;
        it.cyl_radius = r;
        return it;
    endfunction

    task automatic test_directed();
        item_t it;
        // axis at the midpoint, touching the summed radii exactly at the reset radius
        send_item(line_item(0, 0, 10, 0, units(5), 31'(ONE) + 7864, 0, 31'(ONE), 31'(ONE)));
        // one unit further out
        send_item(line_item(0, 0, 10, 0, units(5), 31'(ONE) + 7865, 0, 31'(ONE), 31'(ONE)));
        // height window edges, low and high
        send_item(line_item(0, 0, 10, 0, units(5), 0, 7864, 31'(ONE), 31'(ONE)));
        send_item(line_item(0, 0, 10, 0, units(5), 0, 7865, 31'(ONE), 31'(ONE)));
        send_item(line_item(0, 0, 10, 0, units(5), 0, -(32'(ONE) + 7864), 31'(ONE), 31'(ONE)));
        send_item(line_item(0, 0, 10, 0, units(5), 0, -(32'(ONE) + 7865), 31'(ONE), 31'(ONE)));
        // axis behind the start and beyond the end
        send_item(line_item(0, 0, 10, 0, units(-3), 0, 0, 31'(ONE), 31'(4 * ONE)));
        send_item(line_item(0, 0, 10, 0, units(13), 0, 0, 31'(ONE), 31'(4 * ONE)));
        // fractional t with truncation, negative direction
        send_item(line_item(7, 3, -4, -2, units(1) + 12345, -777, 0, 31'(ONE), 31'(3 * ONE)));
        // segment length just below and just above the threshold
        it = line_item(0, 0, 0, 0, 100, 0, 0, 31'(ONE), 31'(ONE));
        it.seg_end_x = 65;
        send_item(it);
        it.seg_end_x = 66;
        send_item(it);
        it.seg_end_x = 0;
        send_item(it);
        // extremes of every field
        it = '1;
        it.cyl_height = '1;
        send_item(it);
        it = '0;
        send_item(it);
        it.seg_start_x = 32'h8000_0000;
        it.seg_start_y = 32'h8000_0000;
        it.seg_start_z = 32'h8000_0000;
        it.seg_end_x = 32'h7fff_ffff;
        it.seg_end_y = 32'h7fff_ffff;
        it.seg_end_z = 32'h7fff_ffff;
        it.cyl_base_x = 0;
        it.cyl_base_y = 0;
        it.cyl_base_z = 0;
        it.cyl_height = '1;
        it.cyl_radius = '1;
        send_item(it);
        it.cyl_base_x = 32'h7fff_ffff;
        it.cyl_base_z = 32'h8000_0000;
        it.cyl_radius = 0;
        it.cyl_height = 0;
        send_item(it);
        pause_sender(1);
    endtask

    task automatic test_random(input int unsigned n);
        item_t it;
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                it = full_random_item();
            else
                it = near_item();
            send_item(it);
            pause_sender(pick_gap());
            if (i == n / 2)
                drain_results();
        end
        pause_sender(1);
    endtask

    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen++;
            if (pending_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                result_t want;
                want = pending_hits.pop_front();
                if (result.hit)
                    hits_seen++;
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, result);
                end
            end
        end
    end

    // Count cycles with no transfer on either side.
    always @(posedge clk)
    begin
        accepted_now = (start && !busy) || done;
        if (accepted_now || pending_hits.size() == 0 && !start)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_swept_sphere_cylinder_hit_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        items_sent = 0;
        results_seen = 0;
        hits_seen = 0;
        stall_cycles = 0;
        radius_shadow = SPHERE_RADIUS_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300);
        write_radius(31'd0);
        test_directed();
        test_random(200);
        write_radius(31'h7fff_ffff);
        test_random(100);
        write_radius(31'($urandom_range(1, 2 * ONE)));
        test_random(200);
        write_radius(31'($urandom));
        test_random(50);
        write_radius(SPHERE_RADIUS_RESET);
        test_random(150);
        drain_results();
        if (pending_hits.size() != 0)
            mismatches += pending_hits.size();
        $display("sent %0d items over six radius settings, %0d results, %0d hits",
                 items_sent, results_seen, hits_seen);
        if (mismatches == 0)
            $display("tb_swept_sphere_cylinder_hit_top: PASS");
        else
            $display("tb_swept_sphere_cylinder_hit_top: FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/sschit_pkg.sv
hdl/swept_sphere_cylinder_hit_top.sv
hdl/sschit_checker.sv
tb/sv/tb_swept_sphere_cylinder_hit_top.sv
